/* rtl/core/imu_sfc_pkg.sv */
// ----------------------------------------------------------------------------
// imu_sfc_pkg: shared types and constants of the frame checker
// Frame layout constants, the error code type and the result record.
// ----------------------------------------------------------------------------
package imu_sfc_pkg;

  localparam logic [7:0] HDR_BYTE          = 8'h23;
  localparam logic [7:0] FOOT_A            = 8'h0D;
  localparam logic [7:0] FOOT_B            = 8'h0A;
  localparam logic [7:0] FRAME_OVERHEAD    = 8'd18;
  localparam logic [7:0] PAYLOAD_FIRST     = 8'd14;
  localparam logic [7:0] PAYLOAD_MAX       = 8'd237;
  localparam logic [7:0] PAYLOAD_LEN_RESET = 8'd28;
  localparam logic [7:0] STATUS_POS        = 8'd4;
  localparam logic [7:0] COUNTER_POS       = 8'd5;
  localparam logic [7:0] TS_FIRST          = 8'd6;
  localparam logic [7:0] SUM_FIRST         = 8'd3;
  localparam logic [7:0] LEN_POS           = 8'd2;

  // width of out_tdata: 99 payload bits rounded up to whole bytes
  localparam int OUT_DATA_W = 104;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_HEADER   = 3'd1,
    ERR_LENGTH   = 3'd2,
    ERR_FOOTER   = 3'd3,
    ERR_CHECKSUM = 3'd4
  } err_code_t;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_VERDICT = 1'b1
  } res_kind_t;

  typedef struct packed {
    res_kind_t   kind;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_index;
    err_code_t   error_code;
    logic [7:0]  frame_status;
    logic [7:0]  frame_counter;
    logic [63:0] timestamp;
  } result_t;

  // one request held in the input register
  typedef struct packed {
    logic       valid;
    logic       frame_start;
    logic [7:0] data_byte;
  } in_req_t;

endpackage

/* rtl/core/imu_sfc_in_stage.sv */
// ----------------------------------------------------------------------------
// imu_sfc_in_stage: input register
// Holds one request until the checker consumes it.
// ----------------------------------------------------------------------------
module imu_sfc_in_stage
  import imu_sfc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       in_tuser,
  input  logic       consume,
  output in_req_t    req
);

  logic       valid_r;
  logic       start_r;
  logic [7:0] data_r;
  logic       load;

  assign in_tready = !valid_r || consume;
  assign load      = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (consume) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      start_r <= in_tuser;
      data_r  <= in_tdata;
    end
  end

  assign req.valid       = valid_r;
  assign req.frame_start = start_r;
  assign req.data_byte   = data_r;

endmodule

/* rtl/core/imu_sfc_core.sv */
// ----------------------------------------------------------------------------
// imu_sfc_core: frame state and checks
// Byte position, running sum, first error and held header fields.
// ----------------------------------------------------------------------------
module imu_sfc_core
  import imu_sfc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  in_req_t    req,
  input  logic       fire,
  output logic       res_valid,
  output result_t    res
);

  logic [7:0]  flen_r;
  logic [7:0]  pos_r,      pos_nxt;
  logic        in_frame_r, in_frame_nxt;
  logic [15:0] sum_r,      sum_nxt;
  logic [15:0] rsum_r,     rsum_nxt;
  err_code_t   err_r,      err_nxt;
  logic [7:0]  status_r,   status_nxt;
  logic [7:0]  counter_r,  counter_nxt;
  logic [63:0] ts_r,       ts_nxt;

  logic        active;
  logic [7:0]  pos;
  logic [15:0] sum_base;
  logic [15:0] rsum_base;
  err_code_t   err_base;
  logic [7:0]  b;
  logic [7:0]  flen_m4, flen_m3, flen_m2, flen_m1;
  logic [7:0]  cfg_plen;

  // length register, clamped so the frame length fits one byte
  assign cfg_plen = (cfg_wr_data > PAYLOAD_MAX) ? PAYLOAD_MAX : cfg_wr_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flen_r <= FRAME_OVERHEAD + PAYLOAD_LEN_RESET;
    end else if (cfg_wr_en) begin
      flen_r <= FRAME_OVERHEAD + cfg_plen;
    end
  end

  assign flen_m4 = flen_r - 8'd4;
  assign flen_m3 = flen_r - 8'd3;
  assign flen_m2 = flen_r - 8'd2;
  assign flen_m1 = flen_r - 8'd1;

  // frame_start restarts the frame with this byte
  assign b         = req.data_byte;
  assign active    = req.frame_start || in_frame_r;
  assign pos       = req.frame_start ? 8'd0 : pos_r;
  assign sum_base  = req.frame_start ? 16'd0 : sum_r;
  assign rsum_base = req.frame_start ? 16'd0 : rsum_r;
  assign err_base  = req.frame_start ? ERR_NONE : err_r;

  always_comb begin
    pos_nxt      = pos + 8'd1;
    in_frame_nxt = 1'b1;
    sum_nxt      = sum_base;
    rsum_nxt     = rsum_base;
    err_nxt      = err_base;
    status_nxt   = status_r;
    counter_nxt  = counter_r;
    ts_nxt       = ts_r;
    res_valid    = 1'b0;
    res          = '0;

    if (pos >= SUM_FIRST && pos < flen_m4) begin
      sum_nxt = sum_base + {8'd0, b};
    end

    if (pos <= 8'd1) begin
      if (b != HDR_BYTE && err_base == ERR_NONE) err_nxt = ERR_HEADER;
    end else if (pos == LEN_POS) begin
      if (b != flen_r && err_base == ERR_NONE) err_nxt = ERR_LENGTH;
    end else if (pos == STATUS_POS) begin
      status_nxt = b;
    end else if (pos == COUNTER_POS) begin
      counter_nxt = b;
    end else if (pos >= TS_FIRST && pos < PAYLOAD_FIRST) begin
      ts_nxt = {ts_r[55:0], b};
    end else if (pos >= PAYLOAD_FIRST && pos < flen_m4) begin
      res_valid         = 1'b1;
      res.kind          = KIND_PAYLOAD;
      res.payload_byte  = b;
      res.payload_index = pos - PAYLOAD_FIRST;
    end else if (pos == flen_m4) begin
      rsum_nxt = {b, 8'd0};
    end else if (pos == flen_m3) begin
      rsum_nxt = rsum_base | {8'd0, b};
    end else if (pos == flen_m2) begin
      if (b != FOOT_A && err_base == ERR_NONE) err_nxt = ERR_FOOTER;
    end else if (pos == flen_m1) begin
      if (b != FOOT_B && err_base == ERR_NONE) begin
        err_nxt = ERR_FOOTER;
      end else if (rsum_base != sum_base && err_base == ERR_NONE) begin
        err_nxt = ERR_CHECKSUM;
      end
      in_frame_nxt      = 1'b0;
      pos_nxt           = 8'd0;
      res_valid         = 1'b1;
      res.kind          = KIND_VERDICT;
      res.error_code    = err_nxt;
      res.frame_status  = status_r;
      res.frame_counter = counter_r;
      res.timestamp     = ts_r;
    end

    if (!active) begin
      res_valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= 8'd0;
      in_frame_r <= 1'b0;
      sum_r      <= 16'd0;
      rsum_r     <= 16'd0;
      err_r      <= ERR_NONE;
      status_r   <= 8'd0;
      counter_r  <= 8'd0;
      ts_r       <= 64'd0;
    end else if (fire && active) begin
      pos_r      <= pos_nxt;
      in_frame_r <= in_frame_nxt;
      sum_r      <= sum_nxt;
      rsum_r     <= rsum_nxt;
      err_r      <= err_nxt;
      status_r   <= status_nxt;
      counter_r  <= counter_nxt;
      ts_r       <= ts_nxt;
    end
  end

  a_verdict_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res_valid && res.kind == KIND_VERDICT |=> !in_frame_r)
    else $error("frame still open after verdict");

  a_idle_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !in_frame_r |-> pos_r == 8'd0)
    else $error("byte position not cleared outside a frame");

  a_first_error_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !req.frame_start && err_r != ERR_NONE |=> err_r == $past(err_r))
    else $error("first error overwritten within a frame");

endmodule

/* rtl/core/imu_sfc_out_reg.sv */
// ----------------------------------------------------------------------------
// imu_sfc_out_reg: result register
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module imu_sfc_out_reg
  import imu_sfc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  req_valid,
  input  logic                  res_valid,
  input  result_t               res,
  output logic                  fire,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tuser
);

  logic    valid_r;
  result_t res_r;
  logic    slot_free;

  assign slot_free = !valid_r || out_tready;
  assign fire      = req_valid && slot_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (slot_free) begin
      valid_r <= fire && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_valid) begin
      res_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tuser  = res_r.kind;
  assign out_tdata  = {5'd0, res_r.timestamp, res_r.frame_counter, res_r.frame_status,
                       res_r.error_code, res_r.payload_index, res_r.payload_byte};

endmodule

/* rtl/core/imu_stream_frame_checker_unit.sv */
// ----------------------------------------------------------------------------
// imu_stream_frame_checker_unit: sensor streaming frame checker
// Checks frames byte by byte, passes payload bytes on and gives one verdict.
// ----------------------------------------------------------------------------
//
// channel  | dir | payload
// ---------+-----+-------------------------------------------------------
// in_      | in  | tdata data_byte, tuser frame_start
// out_     | out | tdata payload/verdict fields, tuser kind
// cfg_     | in  | wr_data payload_len (clamped to 237)
//
// one byte per clock sustained while out_tready holds; a request accepted into the
// input register is checked there and its result is loaded into the result register
// when the request fires, which a stall on out_tready can hold off; the checks are
// combinational, throughput is set by the single input and result registers
// rst_n is synchronous; after reset the frame length is 46 bytes
// a stall on out_tready stops the checker and then in_tready, no request is lost
//
module imu_stream_frame_checker_unit
  import imu_sfc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] data_byte
  input  logic                  in_tuser,   // [0] frame_start
  // result channel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [7:0] payload_byte, [15:8] payload_index, [18:16] error_code,
  // [26:19] frame_status, [34:27] frame_counter, [98:35] timestamp, rest zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tuser,  // [0] kind
  // configuration
  input  logic                  cfg_wr_en,
  input  logic [7:0]            cfg_wr_data // [7:0] payload_len
);

  in_req_t req;
  logic    fire;
  logic    res_valid;
  result_t res;

  // input register, freed whenever the checker takes its request
  imu_sfc_in_stage u_in_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .consume   (fire),
    .req       (req)
  );

  // frame state machine and checks, updated only when a request fires
  imu_sfc_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req         (req),
    .fire        (fire),
    .res_valid   (res_valid),
    .res         (res)
  );

  // result register, decides when the held request may advance
  imu_sfc_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .res_valid  (res_valid),
    .res        (res),
    .fire       (fire),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  a_no_result_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result pending right after reset");

endmodule

/* test/imu_stream_frame_checker_unit_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// imu_stream_frame_checker_unit_test: regression bench of the frame checker
// Streams well-formed and damaged sensor frames through the checker under
// random input gaps and output stalls. A cycle-free predictor tracks each
// accepted byte and every payload byte and verdict is checked in order.
// ----------------------------------------------------------------------------
module imu_stream_frame_checker_unit_test;
  import imu_sfc_pkg::*;

  // ways a generated frame is damaged before it goes on the link
  typedef enum int {
    FLAW_NONE,
    FLAW_HEADER,
    FLAW_LENGTH,
    FLAW_FOOTER,
    FLAW_SUM,
    FLAW_ANY,
    FLAW_CUT
  } frame_flaw_t;

  // content of the status, counter, timestamp and payload bytes
  typedef enum int {
    FILL_RANDOM,
    FILL_ONES,
    FILL_ZEROS
  } frame_fill_t;

  // one request of the input channel
  typedef struct packed {
    logic       start;
    logic [7:0] data;
  } link_byte_t;

  logic                  clk;
  logic                  rst_n       = 1'b0;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata    = 8'h00;
  logic                  in_tuser    = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  cfg_wr_en   = 1'b0;
  logic [7:0]            cfg_wr_data = 8'h00;

  // stimulus side
  link_byte_t link_bytes[$];
  int         bytes_queued = 0;
  int         bytes_taken  = 0;
  bit         byte_taken   = 1'b0;
  int         in_gap       = 0;
  int         in_calm      = 0;
  int         out_hold     = 0;
  int         out_calm     = 0;
  int         gen_plen     = PAYLOAD_LEN_RESET;

  // predictor state, a private copy of what the checker holds
  logic [7:0]  plen_setting  = PAYLOAD_LEN_RESET;
  logic        frame_open    = 1'b0;
  int          frame_pos     = 0;
  logic [15:0] running_sum   = '0;
  logic [15:0] sent_sum      = '0;
  err_code_t   frame_fault   = ERR_NONE;
  logic [7:0]  status_q      = '0;
  logic [7:0]  counter_q     = '0;
  logic [63:0] timestamp_q   = '0;
  result_t     frame_results_due[$];

  // bookkeeping
  int faults        = 0;
  int payload_seen  = 0;
  int verdicts_seen = 0;
  int settings_used = 1;
  int verdict_codes[5];

  imu_stream_frame_checker_unit i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // gap length: mostly none or short, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic void note_fault(err_code_t code);
    if (frame_fault == ERR_NONE) frame_fault = code;
  endfunction

  // predicted behavior for one accepted byte; results go to the due queue
  task automatic predict_frame_byte(input logic [7:0] b, input logic start);
    int      plen;
    int      flen;
    int      pos;
    result_t r;
    plen = (plen_setting > PAYLOAD_MAX) ? PAYLOAD_MAX : plen_setting;
    flen = FRAME_OVERHEAD + plen;
    // a start drops whatever partial frame was open
    if (start) begin
      frame_open  = 1'b1;
      frame_pos   = 0;
      running_sum = '0;
      sent_sum    = '0;
      frame_fault = ERR_NONE;
    end
    // idle bytes without a start are ignored
    if (!frame_open) return;
    pos = frame_pos;
    r   = '0;
    if (pos >= SUM_FIRST && pos <= flen - 5) running_sum = running_sum + 16'(b);
    if (pos <= 1) begin
      if (b != HDR_BYTE) note_fault(ERR_HEADER);
    end else if (pos == LEN_POS) begin
      if (b != 8'(flen)) note_fault(ERR_LENGTH);
    end else if (pos == STATUS_POS) begin
      status_q = b;
    end else if (pos == COUNTER_POS) begin
      counter_q = b;
    end else if (pos >= TS_FIRST && pos < PAYLOAD_FIRST) begin
      timestamp_q = {timestamp_q[55:0], b};
    end else if (pos >= PAYLOAD_FIRST && pos < PAYLOAD_FIRST + plen) begin
      r.kind          = KIND_PAYLOAD;
      r.payload_byte  = b;
      r.payload_index = 8'(pos - PAYLOAD_FIRST);
      frame_results_due.push_back(r);
    end else if (pos == flen - 4) begin
      sent_sum = {b, 8'h00};
    end else if (pos == flen - 3) begin
      sent_sum[7:0] = b;
    end else if (pos == flen - 2) begin
      if (b != FOOT_A) note_fault(ERR_FOOTER);
    end else if (pos == flen - 1) begin
      // last byte: footer, then checksum, then the verdict
      if (b != FOOT_B) note_fault(ERR_FOOTER);
      if (sent_sum != running_sum) note_fault(ERR_CHECKSUM);
      frame_open      = 1'b0;
      frame_pos       = 0;
      r.kind          = KIND_VERDICT;
      r.error_code    = frame_fault;
      r.frame_status  = status_q;
      r.frame_counter = counter_q;
      r.timestamp     = timestamp_q;
      frame_results_due.push_back(r);
      return;
    end
    frame_pos = pos + 1;
  endtask

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      faults++;
    end
  endfunction

  function automatic void queue_byte(logic [7:0] d, logic s);
    link_bytes.push_back({s, d});
    bytes_queued++;
  endfunction

  // builds one frame for the current payload length, damages it as asked
  task automatic queue_frame(input frame_flaw_t flaw, input frame_fill_t fill);
    logic [7:0]  fb[$];
    logic [15:0] sum;
    int          flen;
    int          cut;
    int          idx;
    flen = FRAME_OVERHEAD + gen_plen;
    fb   = {};
    fb.push_back(HDR_BYTE);
    fb.push_back(HDR_BYTE);
    fb.push_back(8'(flen));
    for (int i = 3; i < PAYLOAD_FIRST + gen_plen; i++) begin
      case (fill)
        FILL_ONES:  fb.push_back(8'hFF);
        FILL_ZEROS: fb.push_back(8'h00);
        default:    fb.push_back(8'($urandom_range(0, 255)));
      endcase
    end
    sum = '0;
    for (int i = SUM_FIRST; i < fb.size(); i++) sum = sum + 16'(fb[i]);
    fb.push_back(sum[15:8]);
    fb.push_back(sum[7:0]);
    fb.push_back(FOOT_A);
    fb.push_back(FOOT_B);
    cut = flen;
    case (flaw)
      FLAW_HEADER: fb[$urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
      FLAW_LENGTH: fb[LEN_POS] ^= 8'($urandom_range(1, 255));
      FLAW_FOOTER: fb[flen - 1 - $urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
      // any one byte of the summed range or the sum itself
      FLAW_SUM:    fb[$urandom_range(SUM_FIRST, flen - 3)] ^= 8'($urandom_range(1, 255));
      FLAW_ANY: begin
        repeat ($urandom_range(1, 3)) begin
          idx     = $urandom_range(0, flen - 1);
          fb[idx] = 8'($urandom_range(0, 255));
        end
      end
      // frame broken off, the next start drops it
      FLAW_CUT:    cut = $urandom_range(1, flen - 1);
      default: ;
    endcase
    for (int i = 0; i < cut; i++) queue_byte(fb[i], i == 0);
  endtask

  // half clean frames, the rest damaged or cut, with stray bytes between
  task automatic queue_random_frames(input int budget);
    int          first;
    int          r;
    frame_flaw_t flaw;
    first = bytes_queued;
    while (bytes_queued - first < budget) begin
      r = $urandom_range(0, 99);
      if (r < 50)      flaw = FLAW_NONE;
      else if (r < 58) flaw = FLAW_HEADER;
      else if (r < 66) flaw = FLAW_LENGTH;
      else if (r < 74) flaw = FLAW_FOOTER;
      else if (r < 84) flaw = FLAW_SUM;
      else if (r < 92) flaw = FLAW_ANY;
      else             flaw = FLAW_CUT;
      queue_frame(flaw, FILL_RANDOM);
      if ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, 4)) queue_byte(8'($urandom_range(0, 255)), 1'b0);
      end
    end
  endtask

  // waits until all requests went in and every result came out, then
  // lets the pipeline run dry in case the last bytes caused no result
  task automatic wait_idle();
    while (!(bytes_taken == bytes_queued && frame_results_due.size() == 0)) @(negedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_payload_len(input logic [7:0] value);
    wait_idle();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    // fill queues at a rising edge only, the driver works on falling ones
    @(posedge clk);
    gen_plen = (value > PAYLOAD_MAX) ? PAYLOAD_MAX : value;
    settings_used++;
  endtask

  // driver: one request at a time from the pending queue
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || byte_taken) begin
      byte_taken = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (link_bytes.size() > 0) begin
        link_byte_t req;
        req = link_bytes.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= req.data;
        in_tuser  <= req.start;
        // calm stretches with no gaps, otherwise random gaps
        if (in_calm > 0) begin
          in_calm--;
          in_gap = 0;
        end else begin
          in_gap = idle_len();
          if ($urandom_range(0, 39) == 0) in_calm = $urandom_range(20, 100);
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver back-pressure, same shape as the input gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b1;
    end else if (out_hold > 0) begin
      out_hold--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (out_calm > 0) begin
        out_calm--;
      end else begin
        out_hold = idle_len();
        if ($urandom_range(0, 39) == 0) out_calm = $urandom_range(20, 100);
      end
    end
  end

  // predictor and monitor share one edge so a result never races its request
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_wr_en) plen_setting = cfg_wr_data;
      if (in_tvalid && in_tready) begin
        predict_frame_byte(in_tdata, in_tuser);
        bytes_taken++;
        byte_taken = 1'b1;
      end
      if (out_tvalid && out_tready) begin
        if (frame_results_due.size() == 0) begin
          $error("result with no request pending: kind %0b tdata %0h", out_tuser, out_tdata);
          faults++;
        end else begin
          result_t want;
          want = frame_results_due.pop_front();
          // tdata: [7:0] byte, [15:8] index, [18:16] code, [26:19] status,
          // [34:27] counter, [98:35] timestamp
          check_field("kind", 64'(want.kind), 64'(out_tuser));
          check_field("payload_byte", 64'(want.payload_byte), 64'(out_tdata[7:0]));
          check_field("payload_index", 64'(want.payload_index), 64'(out_tdata[15:8]));
          check_field("error_code", 64'(want.error_code), 64'(out_tdata[18:16]));
          check_field("frame_status", 64'(want.frame_status), 64'(out_tdata[26:19]));
          check_field("frame_counter", 64'(want.frame_counter), 64'(out_tdata[34:27]));
          check_field("timestamp", want.timestamp, out_tdata[98:35]);
          if (want.kind == KIND_VERDICT) begin
            verdicts_seen++;
            verdict_codes[want.error_code]++;
          end else begin
            payload_seen++;
          end
        end
      end
    end
  end

  initial begin
    foreach (verdict_codes[i]) verdict_codes[i] = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset length of 28 payload bytes, never written yet
    queue_random_frames(30);

    // shortest frame: stray bytes while idle, a broken-off start,
    // then clean frames with every field at its top and then its bottom value
    write_payload_len(8'd0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(HDR_BYTE, 1'b1);
    queue_byte(HDR_BYTE, 1'b0);
    queue_byte(8'd18, 1'b0);
    queue_frame(FLAW_NONE, FILL_ONES);
    queue_frame(FLAW_NONE, FILL_ZEROS);
    queue_random_frames(20);

    // above the limit, clamped to the longest payload, last payload index 236
    write_payload_len(8'd255);
    queue_frame(FLAW_NONE, FILL_ONES);

    // mostly small payloads, now and then a medium one
    repeat (3) begin
      if ($urandom_range(0, 3) == 0) write_payload_len(8'($urandom_range(13, 60)));
      else                           write_payload_len(8'($urandom_range(1, 12)));
      queue_random_frames(15);
    end

    wait_idle();
    $display("checked %0d bytes under %0d payload lengths: %0d payload bytes, %0d verdicts",
             bytes_taken, settings_used, payload_seen, verdicts_seen);
    $display("verdicts ok %0d, header %0d, length %0d, footer %0d, checksum %0d",
             verdict_codes[ERR_NONE], verdict_codes[ERR_HEADER], verdict_codes[ERR_LENGTH],
             verdict_codes[ERR_FOOTER], verdict_codes[ERR_CHECKSUM]);
    if (faults == 0) begin
      $display("imu_stream_frame_checker_unit regression: pass");
    end else begin
      $display("imu_stream_frame_checker_unit regression: fail");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #8ms;
    $display("timeout with %0d requests and %0d results outstanding",
             bytes_queued - bytes_taken, frame_results_due.size());
    $display("imu_stream_frame_checker_unit regression: fail");
    $finish;
  end

endmodule
